// File: hdl/ghacc_pkg.sv
// Shared types, constants and the GF(2^128) multiply for the GHASH accumulator.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package ghacc_pkg;

  localparam int unsigned HALF_W    = 64;
  localparam int unsigned BLOCK_W   = 2 * HALF_W;
  localparam int unsigned PROD_W    = 2 * BLOCK_W - 1;
  localparam int unsigned FOLD_W    = BLOCK_W + 6;
  localparam int unsigned OVF_W     = FOLD_W - BLOCK_W;
  localparam int unsigned CFG_IDX_W = 1;

  // Output queue depth and its counters
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // GCM reduction byte; reflected it gives the x^7 + x^2 + x + 1 tail
  localparam logic [7:0] GCM_R = 8'hE1;

  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [BLOCK_W-1:0] block_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBKEY_HIGH = 1'b0,
    REG_SUBKEY_LOW  = 1'b1
  } cfg_reg_t;

  function automatic block_t bit_rev(input block_t v);
    block_t r;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[i] = v[BLOCK_W-1-i];
    end
    return r;
  endfunction

  // GCM bit order: the MSB of byte 0 is the x^0 coefficient, so reflect,
  // do a plain carryless multiply, fold twice, and reflect back.
  function automatic block_t gf128_mul(input block_t x, input block_t h);
    block_t               xr;
    block_t               hr;
    block_t               res;
    logic [PROD_W-1:0]    prod;
    logic [FOLD_W-1:0]    fold;
    logic [BLOCK_W-2:0]   upper;
    logic [OVF_W-1:0]     ovf;
    xr   = bit_rev(x);
    hr   = bit_rev(h);
    prod = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      if (hr[i]) begin
        prod = prod ^ (PROD_W'(xr) << i);
      end
    end
    upper = prod[PROD_W-1:BLOCK_W];
    fold  = FOLD_W'(prod[BLOCK_W-1:0]);
    for (int j = 0; j < 8; j++) begin
      if (GCM_R[7-j]) begin
        fold = fold ^ (FOLD_W'(upper) << j);
      end
    end
    ovf = fold[FOLD_W-1:BLOCK_W];
    res = fold[BLOCK_W-1:0];
    for (int j = 0; j < 8; j++) begin
      if (GCM_R[7-j]) begin
        res = res ^ (BLOCK_W'(ovf) << j);
      end
    end
    return bit_rev(res);
  endfunction

endpackage

`default_nettype wire

// File: hdl/ghacc_if.sv
// Valid/ready channel interfaces: input blocks and output tags.
// Depends on ghacc_pkg for the field types.
`default_nettype none

interface ghacc_in_if;
  import ghacc_pkg::*;

  logic  valid;
  logic  ready;
  half_t block_high;
  half_t block_low;
  logic  last;

  modport source (output valid, output block_high, output block_low, output last,
                  input ready);
  modport sink   (input valid, input block_high, input block_low, input last,
                  output ready);
endinterface

interface ghacc_out_if;
  import ghacc_pkg::*;

  logic  valid;
  logic  ready;
  half_t hash_high;
  half_t hash_low;

  modport source (output valid, output hash_high, output hash_low, input ready);
  modport sink   (input valid, input hash_high, input hash_low, output ready);
endinterface

`default_nettype wire

// File: hdl/ghash_accumulator_top.sv
// GHASH accumulator: one GF(2^128) multiply by H per block, tag on the last block.
// A tag passes through the input stage (s1) and then the tag queue before tags.valid rises.
// Throughput: one block per cycle, but a last block waits while the tag queue is full.
// A two-entry tag queue lets blocks keep flowing while a tag waits on the sink.
// Reset (rst, synchronous) clears H, the accumulator, the input stage and the queue.
`default_nettype none

module ghash_accumulator_top (
  input  logic                               clk,
  input  logic                               rst,
  ghacc_in_if.sink                           blocks,
  ghacc_out_if.source                        tags,
  input  logic                               cfg_we,
  input  logic [ghacc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ghacc_pkg::HALF_W-1:0]       cfg_data
);
  import ghacc_pkg::*;

  half_t               subkey_high;
  half_t               subkey_low;
  block_t              acc;
  logic                s1_valid;
  logic                s1_last;
  block_t              s1_block;
  block_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   queue_count;
  logic [QCNT_W-1:0]   queue_count_next;

  block_t              product;
  logic                s1_fire;
  logic                in_beat;
  logic                push;
  logic                pop;

  assign product = gf128_mul(acc ^ s1_block, {subkey_high, subkey_low});

  // A last block needs a free queue slot; other blocks always retire
  assign s1_fire      = s1_valid && (!s1_last || (queue_count != QCNT_W'(QUEUE_DEPTH)));
  assign blocks.ready = !s1_valid || s1_fire;
  assign in_beat      = blocks.valid && blocks.ready;
  assign push         = s1_fire && s1_last;
  assign pop          = tags.valid && tags.ready;

  assign tags.valid     = (queue_count != '0);
  assign tags.hash_high = queue[rd_ptr][BLOCK_W-1:HALF_W];
  assign tags.hash_low  = queue[rd_ptr][HALF_W-1:0];

  always_comb begin
    queue_count_next = queue_count;
    if (push && !pop) begin
      queue_count_next = queue_count + QCNT_W'(1);
    end else if (pop && !push) begin
      queue_count_next = queue_count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subkey_high <= '0;
      subkey_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SUBKEY_HIGH: subkey_high <= cfg_data;
        REG_SUBKEY_LOW:  subkey_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else if (blocks.ready) begin
      s1_valid <= blocks.valid;
      s1_last  <= blocks.last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_block <= {blocks.block_high, blocks.block_low};
    end
  end

  // Clear on the last block so the next message starts from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_fire) begin
      acc <= s1_last ? '0 : product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      queue_count <= '0;
    end else begin
      queue_count <= queue_count_next;
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= product;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ghacc_checker.sv
// Port-level assertions for ghash_accumulator_top, attached with bind.
// Depends on ghacc_pkg and on the top level's port names.
`default_nettype none

module ghacc_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_last,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [ghacc_pkg::HALF_W-1:0]       hash_high,
  input  logic [ghacc_pkg::HALF_W-1:0]       hash_low
);
  import ghacc_pkg::*;

  logic in_beat;
  logic last_beat;

  assign in_beat   = in_valid && in_ready;
  assign last_beat = in_beat && in_last;

  // A stalled tag holds its value
  a_tag_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_high) && $stable(hash_low))
    else $error("tag changed or dropped while stalled");

  // With an empty queue, a tag follows its last beat via s1 and the queue
  a_tag_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(last_beat, 2))
    else $error("tag appeared without a matching last block");

  // Input only backs up when the tag queue is holding results
  a_stall_needs_tag: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no tag pending");

  // A stall starts only right after a last block entered
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(last_beat))
    else $error("input stalled without a last block ahead of it");

endmodule

bind ghash_accumulator_top ghacc_checker u_ghacc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (blocks.valid),
  .in_ready  (blocks.ready),
  .in_last   (blocks.last),
  .out_valid (tags.valid),
  .out_ready (tags.ready),
  .hash_high (tags.hash_high),
  .hash_low  (tags.hash_low)
);

`default_nettype wire
